### sv/assert_macros.svh
// assertion macros used by the map unit rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checked on clk and disabled in reset
`define CHK_IMPL(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("same-cycle check failed");

// next-cycle implication, checked on clk and disabled in reset
`define CHK_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("next-cycle check failed");

`endif

### sv/fe2eq_pkg.sv
// types, constants and the arctangent table of the fisheye map unit
package fe2eq_pkg;
	localparam int CFG_W = 13;
	localparam int CFG_IDX_W = 2;
	localparam int CRD_W = 12;
	localparam int OUT_W = 18;
	localparam int MAX_DIM = 4096;
	localparam int ITERS = 16;
	localparam int ANG_W = 20;
	localparam int VEC_W = 26;
	localparam int VX_W = 28;
	localparam int MUL_SH = 24;
	localparam int Q1_W = 18;
	localparam int NUM1_W = 31;
	localparam int Q2_W = 20;
	localparam int NUM2_W = 49;
	localparam int DEN2_W = 31;
	localparam int RW_W = Q2_W + CFG_W;
	localparam int PX_W = RW_W + 1 + VEC_W;
	localparam int SUM_W = 61;
	localparam int POS_FRAC = 40;
	localparam int HALF_PI_Q16 = 102944;
	localparam int PI_Q16 = 205887;
	localparam int TWO_HALF_PI = 2 * HALF_PI_Q16;
	localparam int GAIN_Q24 = 10188014;
	localparam int RSCALE = 5760 * 65536;
	localparam int FOV_MIN = 1440;
	localparam int FOV_MAX = 5760;
	localparam int WIDTH_RST = 1024;
	localparam int HEIGHT_RST = 1024;
	localparam int FOV_RST = 2944;
	localparam int OUT_MIN = -131072;
	localparam int OUT_MAX = 131071;

	localparam logic signed [ANG_W-1:0] HALF_PI_A = ANG_W'(HALF_PI_Q16);
	localparam logic signed [ANG_W-1:0] PI_A = ANG_W'(PI_Q16);
	localparam logic signed [VEC_W-1:0] GAIN_V = VEC_W'(GAIN_Q24);

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_WIDTH = 2'd0,
		REG_HEIGHT = 2'd1,
		REG_FOV = 2'd2
	} cfg_reg_t;

	function automatic logic signed [ANG_W-1:0] atan_q16(input int unsigned i);
		logic signed [ANG_W-1:0] a;
		case (i)
			0: a = ANG_W'(51472);
			1: a = ANG_W'(30386);
			2: a = ANG_W'(16055);
			3: a = ANG_W'(8150);
			4: a = ANG_W'(4091);
			5: a = ANG_W'(2047);
			6: a = ANG_W'(1024);
			7: a = ANG_W'(512);
			8: a = ANG_W'(256);
			9: a = ANG_W'(128);
			10: a = ANG_W'(64);
			11: a = ANG_W'(32);
			12: a = ANG_W'(16);
			13: a = ANG_W'(8);
			14: a = ANG_W'(4);
			default: a = ANG_W'(2);
		endcase
		return a;
	endfunction
endpackage

### sv/fe2eq_div.sv
// pipelined restoring divider, one quotient bit per stage
module fe2eq_div #(
	parameter int NUM_W = 31,
	parameter int DEN_W = 13,
	parameter int Q_W = 18,
	parameter int SIDE_W = 1
) (
	input logic clk,
	input logic arst_n,
	input logic en,
	input logic in_valid,
	input logic [NUM_W-1:0] num,
	input logic [DEN_W-1:0] den,
	input logic [SIDE_W-1:0] side_in,
	output logic out_valid,
	output logic [Q_W-1:0] quot,
	output logic [SIDE_W-1:0] side_out
);
	localparam int CW = (NUM_W > DEN_W + Q_W) ? NUM_W : DEN_W + Q_W;

	logic [Q_W-1:0] v_s;
	logic [CW-1:0] rem_s [Q_W];
	logic [Q_W-1:0] q_s [Q_W];
	logic [DEN_W-1:0] den_s [Q_W];
	logic [SIDE_W-1:0] side_s [Q_W];

	for (genvar j = 0; j < Q_W; j++) begin : g_stage
		localparam int K = Q_W - 1 - j;
		logic vi;
		logic [CW-1:0] ri;
		logic [Q_W-1:0] qi;
		logic [DEN_W-1:0] di;
		logic [SIDE_W-1:0] si;
		logic [CW-1:0] dsh;

		if (j == 0) begin : g_head
			assign vi = in_valid;
			assign ri = CW'(num);
			assign qi = '0;
			assign di = den;
			assign si = side_in;
		end else begin : g_body
			assign vi = v_s[j-1];
			assign ri = rem_s[j-1];
			assign qi = q_s[j-1];
			assign di = den_s[j-1];
			assign si = side_s[j-1];
		end

		assign dsh = CW'(di) << K;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[j] <= 1'b0;
			end else if (en) begin
				v_s[j] <= vi;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				den_s[j] <= di;
				side_s[j] <= si;
				if (ri >= dsh) begin
					rem_s[j] <= ri - dsh;
					q_s[j] <= qi | (Q_W'(1) << K);
				end else begin
					rem_s[j] <= ri;
					q_s[j] <= qi;
				end
			end
		end
	end

	assign out_valid = v_s[Q_W-1];
	assign quot = q_s[Q_W-1];
	assign side_out = side_s[Q_W-1];
endmodule

### sv/fe2eq_rot.sv
// pipelined rotation cordic, one iteration per stage, gives cosine and sine
module fe2eq_rot #(
	parameter int SIDE_W = 1
) (
	input logic clk,
	input logic arst_n,
	input logic en,
	input logic in_valid,
	input logic signed [fe2eq_pkg::ANG_W-1:0] angle,
	input logic [SIDE_W-1:0] side_in,
	output logic out_valid,
	output logic signed [fe2eq_pkg::VEC_W-1:0] cos_v,
	output logic signed [fe2eq_pkg::VEC_W-1:0] sin_v,
	output logic [SIDE_W-1:0] side_out
);
	import fe2eq_pkg::*;

	logic [ITERS-1:0] v_s;
	logic signed [VEC_W-1:0] x_s [ITERS];
	logic signed [VEC_W-1:0] y_s [ITERS];
	logic signed [ANG_W-1:0] z_s [ITERS];
	logic [SIDE_W-1:0] side_s [ITERS];

	for (genvar i = 0; i < ITERS; i++) begin : g_iter
		logic vi;
		logic signed [VEC_W-1:0] xi;
		logic signed [VEC_W-1:0] yi;
		logic signed [ANG_W-1:0] zi;
		logic [SIDE_W-1:0] si;

		if (i == 0) begin : g_head
			assign vi = in_valid;
			assign xi = GAIN_V;
			assign yi = '0;
			assign zi = angle;
			assign si = side_in;
		end else begin : g_body
			assign vi = v_s[i-1];
			assign xi = x_s[i-1];
			assign yi = y_s[i-1];
			assign zi = z_s[i-1];
			assign si = side_s[i-1];
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[i] <= 1'b0;
			end else if (en) begin
				v_s[i] <= vi;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				side_s[i] <= si;
				if (!zi[ANG_W-1]) begin
					x_s[i] <= xi - (yi >>> i);
					y_s[i] <= yi + (xi >>> i);
					z_s[i] <= zi - atan_q16(i);
				end else begin
					x_s[i] <= xi + (yi >>> i);
					y_s[i] <= yi - (xi >>> i);
					z_s[i] <= zi + atan_q16(i);
				end
			end
		end
	end

	assign out_valid = v_s[ITERS-1];
	assign cos_v = x_s[ITERS-1];
	assign sin_v = y_s[ITERS-1];
	assign side_out = side_s[ITERS-1];
endmodule

### sv/fe2eq_vec.sv
// pipelined vectoring cordic with quadrant fold, gives angle and scaled magnitude
module fe2eq_vec #(
	parameter int SIDE_W = 1
) (
	input logic clk,
	input logic arst_n,
	input logic en,
	input logic in_valid,
	input logic signed [fe2eq_pkg::VEC_W-1:0] x_in,
	input logic signed [fe2eq_pkg::VEC_W-1:0] y_in,
	input logic [SIDE_W-1:0] side_in,
	output logic out_valid,
	output logic signed [fe2eq_pkg::VX_W-1:0] x_out,
	output logic signed [fe2eq_pkg::ANG_W-1:0] z_out,
	output logic [SIDE_W-1:0] side_out
);
	import fe2eq_pkg::*;

	logic [ITERS-1:0] v_s;
	logic signed [VX_W-1:0] x_s [ITERS];
	logic signed [VX_W-1:0] y_s [ITERS];
	logic signed [ANG_W-1:0] z_s [ITERS];
	logic [SIDE_W-1:0] side_s [ITERS];

	for (genvar i = 0; i < ITERS; i++) begin : g_iter
		logic vi;
		logic signed [VX_W-1:0] xi;
		logic signed [VX_W-1:0] yi;
		logic signed [ANG_W-1:0] zi;
		logic [SIDE_W-1:0] si;

		if (i == 0) begin : g_head
			logic signed [VX_W-1:0] xe;
			logic signed [VX_W-1:0] ye;
			assign xe = VX_W'(x_in);
			assign ye = VX_W'(y_in);
			assign vi = in_valid;
			assign si = side_in;
			// fold the left half plane onto the right
			always_comb begin
				if (xe < 0) begin
					if (ye >= 0) begin
						xi = ye;
						yi = -xe;
						zi = HALF_PI_A;
					end else begin
						xi = -ye;
						yi = xe;
						zi = -HALF_PI_A;
					end
				end else begin
					xi = xe;
					yi = ye;
					zi = '0;
				end
			end
		end else begin : g_body
			assign vi = v_s[i-1];
			assign xi = x_s[i-1];
			assign yi = y_s[i-1];
			assign zi = z_s[i-1];
			assign si = side_s[i-1];
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[i] <= 1'b0;
			end else if (en) begin
				v_s[i] <= vi;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				side_s[i] <= si;
				if (yi > 0) begin
					x_s[i] <= xi + (yi >>> i);
					y_s[i] <= yi - (xi >>> i);
					z_s[i] <= zi + atan_q16(i);
				end else begin
					x_s[i] <= xi - (yi >>> i);
					y_s[i] <= yi + (xi >>> i);
					z_s[i] <= zi - atan_q16(i);
				end
			end
		end
	end

	assign out_valid = v_s[ITERS-1];
	assign x_out = x_s[ITERS-1];
	assign z_out = z_s[ITERS-1];
	assign side_out = side_s[ITERS-1];
endmodule

### sv/fisheye_to_equirect_map_unit.sv
// throughput: one word per cycle; the whole pipeline advances unless the output waits
// the depth comes from two 18/20-stage dividers and four 16-stage cordic pipelines
// reset clears all valid bits and loads the default width, height and field of view
// payload registers are not reset
module fisheye_to_equirect_map_unit #(
	parameter int SUBPIXEL_BITS = 4
) (
	input logic clk,
	input logic arst_n,
	input logic cfg_wr_en,
	input logic [fe2eq_pkg::CFG_IDX_W-1:0] cfg_index,
	input logic [fe2eq_pkg::CFG_W-1:0] cfg_data,
	input logic coord_valid,
	output logic coord_ready,
	input logic [fe2eq_pkg::CRD_W-1:0] out_col,
	input logic [fe2eq_pkg::CRD_W-1:0] out_row,
	output logic map_valid,
	input logic map_ready,
	output logic signed [fe2eq_pkg::OUT_W-1:0] src_x,
	output logic signed [fe2eq_pkg::OUT_W-1:0] src_y
);
	import fe2eq_pkg::*;
	`include "assert_macros.svh"

	localparam int SH = POS_FRAC + 1 - SUBPIXEL_BITS;
	localparam logic signed [SUM_W-1:0] HALF_S = SUM_W'(1) << (SH - 1);
	localparam logic signed [SUM_W-1:0] OUT_MIN_S = SUM_W'(OUT_MIN);
	localparam logic signed [SUM_W-1:0] OUT_MAX_S = SUM_W'(OUT_MAX);
	localparam int SIDE3_W = 1 + 2 * RW_W;

	logic en;
	logic [CFG_W-1:0] width_q, height_q, fov_q;
	logic [CFG_W-1:0] wc, hc, fovc, wm1, hm1;
	logic [DEN2_W-1:0] den_q;
	logic [CRD_W-1:0] col_c, row_c;

	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7, v_s8, v_s9;
	logic v_d1, v_r1, v_v1, v_v2, v_d2, v_r3;
	logic [NUM1_W-1:0] numt_s1, nump_s1;
	logic [Q1_W-1:0] qt, qp;
	logic signed [ANG_W-1:0] theta_s2, phi_s2;
	logic signed [VEC_W-1:0] ct, st, cp, sp;
	logic signed [2*VEC_W-1:0] pxs, pys;
	logic signed [VEC_W-1:0] sx_s3, sy_s3, sz_s3;
	logic signed [VX_W-1:0] xr1;
	logic signed [ANG_W-1:0] dir1;
	logic [VEC_W-1:0] sy_v1;
	logic signed [VX_W+VEC_W-1:0] rho_p;
	logic signed [VEC_W-1:0] rho_s4, sy_s4;
	logic signed [ANG_W-1:0] dir_s4;
	logic signed [ANG_W-1:0] off2;
	logic [ANG_W-1:0] dir_v2;
	logic [ANG_W-2:0] offc;
	logic [NUM2_W-1:0] numr_s5;
	logic [ANG_W-1:0] dir_s5;
	logic [Q2_W-1:0] rq;
	logic [ANG_W-1:0] dir_d2;
	logic signed [ANG_W-1:0] dir_r;
	logic signed [ANG_W-1:0] ang_s6;
	logic neg_s6;
	logic [RW_W-1:0] rw_s6, rh_s6;
	logic signed [VEC_W-1:0] cd, sd;
	logic [SIDE3_W-1:0] side3;
	logic signed [VEC_W-1:0] cdn_s7, sdn_s7;
	logic [RW_W-1:0] rw_s7, rh_s7;
	logic signed [PX_W-1:0] px_s8, py_s8;
	logic signed [SUM_W-1:0] wpos, hpos, sumx, sumy;
	logic signed [SUM_W-1:0] fx_s9, fy_s9;

	assign en = !map_valid || map_ready;
	assign coord_ready = en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q <= CFG_W'(WIDTH_RST);
			height_q <= CFG_W'(HEIGHT_RST);
			fov_q <= CFG_W'(FOV_RST);
			den_q <= DEN2_W'(FOV_RST * PI_Q16);
		end else begin
			den_q <= DEN2_W'(fovc) * DEN2_W'(PI_Q16);
			if (cfg_wr_en) begin
				unique case (cfg_index)
					REG_WIDTH: width_q <= cfg_data;
					REG_HEIGHT: height_q <= cfg_data;
					REG_FOV: fov_q <= cfg_data;
					default: ;
				endcase
			end
		end
	end

	always_comb begin
		if (int'(width_q) < 2) begin
			wc = CFG_W'(2);
		end else if (int'(width_q) > MAX_DIM) begin
			wc = CFG_W'(MAX_DIM);
		end else begin
			wc = width_q;
		end
		if (int'(height_q) < 2) begin
			hc = CFG_W'(2);
		end else if (int'(height_q) > MAX_DIM) begin
			hc = CFG_W'(MAX_DIM);
		end else begin
			hc = height_q;
		end
		if (int'(fov_q) < FOV_MIN) begin
			fovc = CFG_W'(FOV_MIN);
		end else if (int'(fov_q) > FOV_MAX) begin
			fovc = CFG_W'(FOV_MAX);
		end else begin
			fovc = fov_q;
		end
	end

	assign wm1 = wc - CFG_W'(1);
	assign hm1 = hc - CFG_W'(1);
	assign col_c = ({1'b0, out_col} > wm1) ? CRD_W'(wm1) : out_col;
	assign row_c = ({1'b0, out_row} > hm1) ? CRD_W'(hm1) : out_row;

	fe2eq_div #(.NUM_W(NUM1_W), .DEN_W(CFG_W), .Q_W(Q1_W), .SIDE_W(1)) u_div_theta (
		.clk(clk), .arst_n(arst_n), .en(en), .in_valid(v_s1),
		.num(numt_s1), .den(wm1), .side_in(1'b0),
		.out_valid(v_d1), .quot(qt), .side_out()
	);

	fe2eq_div #(.NUM_W(NUM1_W), .DEN_W(CFG_W), .Q_W(Q1_W), .SIDE_W(1)) u_div_phi (
		.clk(clk), .arst_n(arst_n), .en(en), .in_valid(v_s1),
		.num(nump_s1), .den(hm1), .side_in(1'b0),
		.out_valid(), .quot(qp), .side_out()
	);

	fe2eq_rot #(.SIDE_W(1)) u_rot_theta (
		.clk(clk), .arst_n(arst_n), .en(en), .in_valid(v_s2),
		.angle(theta_s2), .side_in(1'b0),
		.out_valid(v_r1), .cos_v(ct), .sin_v(st), .side_out()
	);

	fe2eq_rot #(.SIDE_W(1)) u_rot_phi (
		.clk(clk), .arst_n(arst_n), .en(en), .in_valid(v_s2),
		.angle(phi_s2), .side_in(1'b0),
		.out_valid(), .cos_v(cp), .sin_v(sp), .side_out()
	);

	assign pxs = cp * st;
	assign pys = cp * ct;

	fe2eq_vec #(.SIDE_W(VEC_W)) u_vec_dir (
		.clk(clk), .arst_n(arst_n), .en(en), .in_valid(v_s3),
		.x_in(sx_s3), .y_in(sz_s3), .side_in(sy_s3),
		.out_valid(v_v1), .x_out(xr1), .z_out(dir1), .side_out(sy_v1)
	);

	assign rho_p = xr1 * GAIN_V;

	fe2eq_vec #(.SIDE_W(ANG_W)) u_vec_axis (
		.clk(clk), .arst_n(arst_n), .en(en), .in_valid(v_s4),
		.x_in(sy_s4), .y_in(rho_s4), .side_in(dir_s4),
		.out_valid(v_v2), .x_out(), .z_out(off2), .side_out(dir_v2)
	);

	assign offc = off2[ANG_W-1] ? '0 : off2[ANG_W-2:0];

	fe2eq_div #(.NUM_W(NUM2_W), .DEN_W(DEN2_W), .Q_W(Q2_W), .SIDE_W(ANG_W)) u_div_rad (
		.clk(clk), .arst_n(arst_n), .en(en), .in_valid(v_s5),
		.num(numr_s5), .den(den_q), .side_in(dir_s5),
		.out_valid(v_d2), .quot(rq), .side_out(dir_d2)
	);

	assign dir_r = $signed(dir_d2);

	fe2eq_rot #(.SIDE_W(SIDE3_W)) u_rot_dir (
		.clk(clk), .arst_n(arst_n), .en(en), .in_valid(v_s6),
		.angle(ang_s6), .side_in({neg_s6, rw_s6, rh_s6}),
		.out_valid(v_r3), .cos_v(cd), .sin_v(sd), .side_out(side3)
	);

	assign wpos = $signed({{(SUM_W - CFG_W - POS_FRAC){1'b0}}, wc, {POS_FRAC{1'b0}}});
	assign hpos = $signed({{(SUM_W - CFG_W - POS_FRAC){1'b0}}, hc, {POS_FRAC{1'b0}}});
	assign sumx = wpos + SUM_W'(px_s8) + HALF_S;
	assign sumy = hpos - SUM_W'(py_s8) + HALF_S;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
			v_s7 <= 1'b0;
			v_s8 <= 1'b0;
			v_s9 <= 1'b0;
			map_valid <= 1'b0;
		end else if (en) begin
			v_s1 <= coord_valid;
			v_s2 <= v_d1;
			v_s3 <= v_r1;
			v_s4 <= v_v1;
			v_s5 <= v_v2;
			v_s6 <= v_d2;
			v_s7 <= v_r3;
			v_s8 <= v_s7;
			v_s9 <= v_s8;
			map_valid <= v_s9;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			numt_s1 <= NUM1_W'(col_c) * NUM1_W'(TWO_HALF_PI) + NUM1_W'(wm1 >> 1);
			nump_s1 <= NUM1_W'(row_c) * NUM1_W'(TWO_HALF_PI) + NUM1_W'(hm1 >> 1);

			theta_s2 <= $signed({{(ANG_W - Q1_W){1'b0}}, qt}) - HALF_PI_A;
			phi_s2 <= HALF_PI_A - $signed({{(ANG_W - Q1_W){1'b0}}, qp});

			sx_s3 <= VEC_W'(pxs >>> MUL_SH);
			sy_s3 <= VEC_W'(pys >>> MUL_SH);
			sz_s3 <= sp;

			rho_s4 <= VEC_W'(rho_p >>> MUL_SH);
			sy_s4 <= $signed(sy_v1);
			dir_s4 <= dir1;

			numr_s5 <= NUM2_W'(offc) * NUM2_W'(RSCALE) + NUM2_W'(den_q >> 1);
			dir_s5 <= dir_v2;

			// fold the direction into the right half plane and flip the result back
			if (dir_r > HALF_PI_A) begin
				ang_s6 <= dir_r - PI_A;
				neg_s6 <= 1'b1;
			end else if (dir_r < -HALF_PI_A) begin
				ang_s6 <= dir_r + PI_A;
				neg_s6 <= 1'b1;
			end else begin
				ang_s6 <= dir_r;
				neg_s6 <= 1'b0;
			end
			rw_s6 <= RW_W'(rq) * RW_W'(wc);
			rh_s6 <= RW_W'(rq) * RW_W'(hc);

			cdn_s7 <= side3[SIDE3_W-1] ? -cd : cd;
			sdn_s7 <= side3[SIDE3_W-1] ? -sd : sd;
			rw_s7 <= side3[2*RW_W-1:RW_W];
			rh_s7 <= side3[RW_W-1:0];

			px_s8 <= $signed({1'b0, rw_s7}) * cdn_s7;
			py_s8 <= $signed({1'b0, rh_s7}) * sdn_s7;

			fx_s9 <= sumx >>> SH;
			fy_s9 <= sumy >>> SH;

			if (fx_s9 > OUT_MAX_S) begin
				src_x <= OUT_W'(OUT_MAX);
			end else if (fx_s9 < OUT_MIN_S) begin
				src_x <= OUT_W'(OUT_MIN);
			end else begin
				src_x <= OUT_W'(fx_s9);
			end
			if (fy_s9 > OUT_MAX_S) begin
				src_y <= OUT_W'(OUT_MAX);
			end else if (fy_s9 < OUT_MIN_S) begin
				src_y <= OUT_W'(OUT_MIN);
			end else begin
				src_y <= OUT_W'(fy_s9);
			end
		end
	end

	`CHK_NEXT(a_accept_lands, coord_valid && coord_ready, v_s1)
	`CHK_NEXT(a_drain_empties, map_valid && map_ready && !v_s9, !map_valid)
	`CHK_NEXT(a_stall_holds, !coord_ready, $stable(v_s5) && $stable(v_s9))
	`CHK_NEXT(a_den_tracks, 1'b1, den_q == DEN2_W'($past(fovc)) * DEN2_W'(PI_Q16))
endmodule
